/* hw/rtl/imad_pkg.sv */
`default_nettype none
package imad_pkg;

    localparam int unsigned PRED_W = 16;
    localparam int unsigned IDX_W  = 7;
    localparam int unsigned STEP_W = 15;
    localparam int unsigned POS_W  = 3;

    localparam logic [IDX_W-1:0] MAX_STEP_INDEX = 7'd88;

    localparam logic signed [PRED_W-1:0] PRED_MAX = 16'sh7FFF;
    localparam logic signed [PRED_W-1:0] PRED_MIN = -16'sh7FFF;

    // header byte positions; HDR_DONE means data bytes follow
    localparam logic [POS_W-1:0] HDR_PRED_LO = 3'd0;
    localparam logic [POS_W-1:0] HDR_PRED_HI = 3'd1;
    localparam logic [POS_W-1:0] HDR_STEP_LO = 3'd2;
    localparam logic [POS_W-1:0] HDR_STEP_HI = 3'd3;
    localparam logic [POS_W-1:0] HDR_DONE    = 3'd4;

    typedef struct packed {
        logic signed [PRED_W-1:0] predictor;
        logic [IDX_W-1:0]         step_idx;
    } dec_state_t;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
        15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
        15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
        15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
        15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
        15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
        15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
        15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
        15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
        15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
        15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] i;
        i = (idx > MAX_STEP_INDEX) ? MAX_STEP_INDEX : idx;
        return STEP_TABLE[i];
    endfunction

    // -1 for magnitudes 0..3, then 2, 4, 6, 8
    function automatic logic signed [4:0] index_adjust(input logic [3:0] code);
        logic [2:0] m;
        m = {1'b0, code[1:0]} + 3'd1;
        return code[2] ? $signed({1'b0, m, 1'b0}) : -5'sd1;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/imad_if.sv */
`default_nettype none
interface imad_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_block;

    modport source (output valid, output data_byte, output start_of_block, input ready);
    modport sink   (input valid, input data_byte, input start_of_block, output ready);
endinterface

interface imad_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last_of_pair;

    modport source (output valid, output sample, output last_of_pair, input ready);
    modport sink   (input valid, input sample, input last_of_pair, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ima_adpcm_nibble_decoder_core.sv */
`default_nettype none
// 4-bit IMA ADPCM decoder, one stream byte per input beat.
// bytes: data_byte plus start_of_block; a marked byte opens a 4-byte header
//   (predictor low, predictor high, step index low, step index high).
//   Header bytes give no output. After reset the first four bytes are a header.
// samples: one signed 16-bit sample per beat, low nibble first; last_of_pair
//   is set on the high-nibble sample.
// A data byte waits in the input register while its nibbles are decoded in turn
//   into the output register, low nibble first, then high nibble.
// The input register frees a header byte as soon as it is taken, a data byte only
//   after both nibbles have passed the single nibble decoder that they share.
// A one-byte input register decouples the channels; bytes.ready is high when
//   that register is empty or is being drained in the same cycle.
// When samples.ready is low the output register holds and the input stalls
//   once the held byte is waiting on it; nothing is dropped.
// Reset clears the header position, predictor, step index and both valids.
module ima_adpcm_nibble_decoder_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    imad_byte_if.sink            bytes,
    imad_sample_if.source        samples
);

    logic                          buf_valid_reg;
    logic [7:0]                    buf_byte_reg;
    logic                          buf_start_reg;
    logic                          phase_reg;
    logic                          phase_next;
    logic [imad_pkg::POS_W-1:0]    hdr_pos_reg;
    logic [imad_pkg::POS_W-1:0]    hdr_pos_next;
    imad_pkg::dec_state_t          st_reg;
    imad_pkg::dec_state_t          st_next;
    imad_pkg::dec_state_t          dec_out;
    logic                          out_valid_reg;
    logic signed [15:0]            out_sample_reg;
    logic                          out_last_reg;

    logic [imad_pkg::POS_W-1:0]    eff_pos;
    logic                          is_hdr;
    logic                          out_free;
    logic                          proc_hdr;
    logic                          proc_dat;
    logic                          buf_done;
    logic                          in_fire;
    logic [3:0]                    code;

    assign eff_pos  = buf_start_reg ? imad_pkg::HDR_PRED_LO : hdr_pos_reg;
    assign is_hdr   = (eff_pos != imad_pkg::HDR_DONE);
    assign out_free = !out_valid_reg || samples.ready;
    assign proc_hdr = buf_valid_reg && is_hdr;
    assign proc_dat = buf_valid_reg && !is_hdr && out_free;
    assign buf_done = proc_hdr || (proc_dat && phase_reg);
    assign in_fire  = bytes.valid && bytes.ready;
    assign code     = phase_reg ? buf_byte_reg[7:4] : buf_byte_reg[3:0];

    assign bytes.ready          = !buf_valid_reg || buf_done;
    assign samples.valid        = out_valid_reg;
    assign samples.sample       = out_sample_reg;
    assign samples.last_of_pair = out_last_reg;

    imad_nibble_dec u_dec (
        .cur  (st_reg),
        .code (code),
        .nxt  (dec_out)
    );

    always_comb
    begin
        st_next      = st_reg;
        hdr_pos_next = hdr_pos_reg;
        phase_next   = phase_reg;
        if (proc_hdr)
        begin
            case (eff_pos)
                imad_pkg::HDR_PRED_LO:
                begin
                    st_next.predictor[7:0] = buf_byte_reg;
                end
                imad_pkg::HDR_PRED_HI:
                begin
                    st_next.predictor[15:8] = buf_byte_reg;
                end
                imad_pkg::HDR_STEP_LO:
                begin
                    st_next.step_idx = (buf_byte_reg > {1'b0, imad_pkg::MAX_STEP_INDEX}) ?
                                       imad_pkg::MAX_STEP_INDEX : buf_byte_reg[6:0];
                end
                imad_pkg::HDR_STEP_HI:
                begin
                    if (buf_byte_reg != 8'd0)
                    begin
                        st_next.step_idx = imad_pkg::MAX_STEP_INDEX;
                    end
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
            hdr_pos_next = eff_pos + 3'd1;
        end
        else if (proc_dat)
        begin
            st_next    = dec_out;
            phase_next = !phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            buf_start_reg <= 1'b0;
            phase_reg     <= 1'b0;
            hdr_pos_reg   <= imad_pkg::HDR_PRED_LO;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                buf_valid_reg <= 1'b1;
                buf_start_reg <= bytes.start_of_block;
            end
            else if (buf_done)
            begin
                buf_valid_reg <= 1'b0;
            end
            phase_reg   <= phase_next;
            hdr_pos_reg <= hdr_pos_next;
            st_reg      <= st_next;
            if (proc_dat)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (samples.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_byte_reg <= bytes.data_byte;
        end
        if (proc_dat)
        begin
            out_sample_reg <= dec_out.predictor;
            out_last_reg   <= phase_reg;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/imad_nibble_dec.sv */
`default_nettype none
module imad_nibble_dec (
    input  imad_pkg::dec_state_t cur,
    input  logic [3:0]           code,
    output imad_pkg::dec_state_t nxt
);

    logic [imad_pkg::IDX_W-1:0]  idx;
    logic [imad_pkg::STEP_W-1:0] step;
    logic [15:0]                 diff;
    logic signed [8:0]           idx_sum;
    logic signed [17:0]          acc;

    assign idx  = (cur.step_idx > imad_pkg::MAX_STEP_INDEX) ?
                  imad_pkg::MAX_STEP_INDEX : cur.step_idx;
    assign step = imad_pkg::step_size(idx);

    always_comb
    begin
        diff = {4'd0, step[14:3]};
        if (code[0])
        begin
            diff = diff + {3'd0, step[14:2]};
        end
        if (code[1])
        begin
            diff = diff + {2'd0, step[14:1]};
        end
        if (code[2])
        begin
            diff = diff + {1'b0, step};
        end
    end

    always_comb
    begin
        idx_sum = $signed({2'b00, idx}) + 9'(imad_pkg::index_adjust(code));
        if (idx_sum < 9'sd0)
        begin
            nxt.step_idx = '0;
        end
        else if (idx_sum > $signed({2'b00, imad_pkg::MAX_STEP_INDEX}))
        begin
            nxt.step_idx = imad_pkg::MAX_STEP_INDEX;
        end
        else
        begin
            nxt.step_idx = idx_sum[imad_pkg::IDX_W-1:0];
        end
    end

    // sign bit of the code selects subtract; each direction saturates on its own side
    always_comb
    begin
        if (!code[3])
        begin
            acc = 18'(cur.predictor) + $signed({2'b00, diff});
            nxt.predictor = (acc > 18'(imad_pkg::PRED_MAX)) ?
                            imad_pkg::PRED_MAX : acc[15:0];
        end
        else
        begin
            acc = 18'(cur.predictor) - $signed({2'b00, diff});
            nxt.predictor = (acc < 18'(imad_pkg::PRED_MIN)) ?
                            imad_pkg::PRED_MIN : acc[15:0];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/imad_checker.sv */
`default_nettype none
module imad_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_sample,
    input wire logic        out_last
);

    logic half_reg;
    logic out_fire;

    assign out_fire = out_valid && out_ready;

    // set between the low-nibble beat and the high-nibble beat of one byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            half_reg <= !out_last;
        end
    end

    a_high_follows_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_last |-> half_reg)
        else $error("high-nibble sample without a low-nibble sample before it");

    a_low_after_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_last |-> !half_reg)
        else $error("low-nibble sample while a pair is still open");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
        else $error("sample beat changed while stalled");

endmodule

bind ima_adpcm_nibble_decoder_core imad_checker u_imad_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (samples.valid),
    .out_ready  (samples.ready),
    .out_sample (samples.sample),
    .out_last   (samples.last_of_pair)
);
`default_nettype wire
